// ===== rtl/sde_pkg.sv =====
// Shared types and constants of the sediment delivery export block.
`default_nettype none
package sde_pkg;

	localparam logic [30:0] Q30_ONE   = 31'd1073741824;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam int          TAY_TERMS = 10;

	typedef enum logic [1:0] {
		ACT_SCAN    = 2'd0,
		ACT_COMPUTE = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_UNUSED  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_DECAY    = 3'd0,
		REG_LOSS_ND  = 3'd1,
		REG_LOSS_EN  = 3'd2,
		REG_FLOW_ND  = 3'd3,
		REG_FLOW_EN  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       mul_p;
		logic       mul_y;
		logic       add_y;
		logic       mul_g;
		logic       tay_mul;
		logic       tay_div;
		logic [3:0] tay_n;
		logic       scale;
		logic       mul_loss;
		logic       commit;
	} sde_cmd_t;

	typedef struct packed {
		logic fast;
		logic skip_div;
	} sde_stat_t;

	// ceil(2^34 / n): floor(a / n) == (a * r) >> 34 for a < 2^30
	function automatic logic [34:0] recip(input logic [3:0] n);
		logic [34:0] r;
		unique case (n)
			4'd1:    r = 35'd17179869184;
			4'd2:    r = 35'd8589934592;
			4'd3:    r = 35'd5726623062;
			4'd4:    r = 35'd4294967296;
			4'd5:    r = 35'd3435973837;
			4'd6:    r = 35'd2863311531;
			4'd7:    r = 35'd2454267027;
			4'd8:    r = 35'd2147483648;
			4'd9:    r = 35'd1908874354;
			4'd10:   r = 35'd1717986919;
			default: r = 35'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sde_ctrl.sv =====
// Sequencing state machine of the sediment delivery export block.
`default_nettype none
module sde_ctrl
	import sde_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire sde_stat_t stat,
	output sde_cmd_t       cmd
);

	localparam int CW = $clog2(FRAC_BITS);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DIV    = 11'b000_0000_0010,
		ST_XMUL   = 11'b000_0000_0100,
		ST_YMUL   = 11'b000_0000_1000,
		ST_YADD   = 11'b000_0001_0000,
		ST_GMUL   = 11'b000_0010_0000,
		ST_TMUL   = 11'b000_0100_0000,
		ST_TDIV   = 11'b000_1000_0000,
		ST_SCALE  = 11'b001_0000_0000,
		ST_LMUL   = 11'b010_0000_0000,
		ST_COMMIT = 11'b100_0000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [3:0]    n_q;
	logic          out_valid_q;
	logic          accept;

	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul_p    = (state_q == ST_XMUL);
		cmd.mul_y    = (state_q == ST_YMUL);
		cmd.add_y    = (state_q == ST_YADD);
		cmd.mul_g    = (state_q == ST_GMUL);
		cmd.tay_mul  = (state_q == ST_TMUL);
		cmd.tay_div  = (state_q == ST_TDIV);
		cmd.tay_n    = n_q;
		cmd.scale    = (state_q == ST_SCALE);
		cmd.mul_loss = (state_q == ST_LMUL);
		cmd.commit   = (state_q == ST_COMMIT);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !stat.fast)
					state_d = stat.skip_div ? ST_XMUL : ST_DIV;
			end
			ST_DIV:    if (cnt_q == CW'(FRAC_BITS - 1)) state_d = ST_XMUL;
			ST_XMUL:   state_d = ST_YMUL;
			ST_YMUL:   state_d = ST_YADD;
			ST_YADD:   state_d = ST_GMUL;
			ST_GMUL:   state_d = ST_TMUL;
			ST_TMUL:   state_d = ST_TDIV;
			ST_TDIV:   state_d = (n_q == 4'(TAY_TERMS)) ? ST_SCALE : ST_TMUL;
			ST_SCALE:  state_d = ST_LMUL;
			ST_LMUL:   state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= 4'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + CW'(1);
			else
				cnt_q <= '0;
			if (state_q == ST_TDIV)
				n_q <= n_q + 4'd1;
			else if (state_q != ST_TMUL)
				n_q <= 4'd1;
			if ((accept && stat.fast) || state_q == ST_COMMIT)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sde_dpath.sv =====
// Datapath: settings, running state, divider, exponential and scaling.
`default_nettype none
module sde_dpath
	import sde_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic [1:0]   s_tuser,
	input  wire logic [63:0]  s_tdata,
	input  wire sde_cmd_t     cmd,
	output sde_stat_t         stat,
	output logic [159:0]      m_tdata,
	output logic              m_tuser
);

	localparam int T_W    = FRAC_BITS + 1;
	localparam int BETA_W = (FRAC_BITS + 1 > 23) ? FRAC_BITS + 1 : 23;
	localparam int P_W    = BETA_W + T_W;
	localparam int SHR    = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
	localparam int SHL    = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;

	logic [BETA_W-1:0]  beta_q;
	logic signed [31:0] lnd_val_q, fnd_val_q;
	logic               lnd_en_q, fnd_en_q;

	logic [30:0]        max_q;
	logic signed [63:0] sum_q;
	logic [31:0]        cnt_q;
	logic [31:0]        exp_q;
	logic               pv_q;

	logic signed [31:0] loss_q;
	logic [30:0]        den_q;
	logic [31:0]        rem_q;
	logic [T_W-1:0]     t_q;
	logic [P_W-1:0]     p_q;
	logic [56:0]        hi_q;
	logic [30:0]        lo_q;
	logic [57:0]        y_q;
	logic [29:0]        g_q;
	logic [4:0]         k_q;
	logic               kbig_q;
	logic [30:0]        term_q, tp_q;
	logic signed [32:0] esum_q;
	logic [30:0]        sdr_q;
	logic [62:0]        prod_q;

	action_t            action;
	logic signed [31:0] loss_in, flow_in;
	logic               flow_nd, loss_nd;
	logic [30:0]        m;
	logic               flow_ge_m, flow_le_0;
	logic [32:0]        rs;
	logic [63:0]        x30;
	logic [60:0]        xf_prod;
	logic [60:0]        tg_prod;
	logic [65:0]        td_prod;
	logic [59:0]        g_prod;
	logic [30:0]        e_pos;
	logic [32:0]        rnd;
	logic signed [32:0] v;
	logic [64:0]        s65;
	logic [31:0]        mag;

	assign action    = action_t'(s_tuser);
	assign loss_in   = s_tdata[31:0];
	assign flow_in   = s_tdata[63:32];
	assign flow_nd   = fnd_en_q && (flow_in == fnd_val_q);
	assign loss_nd   = lnd_en_q && (loss_in == lnd_val_q);
	assign m         = (max_q == 31'd0) ? 31'd1 : max_q;
	assign flow_ge_m = flow_in >= $signed({1'b0, m});
	assign flow_le_0 = flow_in <= 32'sd0;

	assign stat.fast     = (action != ACT_COMPUTE) || flow_nd || loss_nd;
	assign stat.skip_div = flow_ge_m || flow_le_0;

	assign rs      = {rem_q, 1'b0};
	assign x30     = (64'(p_q) >> SHR) << SHL;
	assign xf_prod = 61'(x30[29:0]) * 61'(LOG2E_Q30);
	assign g_prod  = 60'(y_q[29:0]) * 60'(LN2_Q30);
	assign tg_prod = 61'(term_q) * 61'(g_q);
	assign td_prod = 66'(tp_q) * 66'(recip(cmd.tay_n));
	assign e_pos   = esum_q[32] ? 31'd0 : esum_q[30:0];
	assign mag     = loss_q[31] ? 32'(-loss_q) : 32'(loss_q);
	assign rnd     = 33'((prod_q + 63'd536870912) >> 30);
	assign v       = loss_q[31] ? -$signed(rnd) : $signed(rnd);
	assign s65     = {sum_q[63], sum_q} + {{32{v[32]}}, v};

	assign m_tdata = {1'b0, cnt_q, sum_q, max_q, exp_q};
	assign m_tuser = pv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q    <= BETA_W'(1) << FRAC_BITS;
			lnd_val_q <= '0;
			lnd_en_q  <= 1'b0;
			fnd_val_q <= '0;
			fnd_en_q  <= 1'b0;
			max_q     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_DECAY:   beta_q    <= BETA_W'(cfg_data[22:0]);
					REG_LOSS_ND: lnd_val_q <= cfg_data;
					REG_LOSS_EN: lnd_en_q  <= cfg_data[0];
					REG_FLOW_ND: fnd_val_q <= cfg_data;
					REG_FLOW_EN: fnd_en_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load && stat.fast) begin
				unique case (action)
					ACT_SCAN: begin
						if (!flow_nd && flow_in > $signed({1'b0, max_q}))
							max_q <= flow_in[30:0];
					end
					ACT_CLEAR: begin
						max_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
					end
					ACT_COMPUTE, ACT_UNUSED: ;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				if (s65[64] != s65[63])
					sum_q <= s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				else
					sum_q <= s65[63:0];
				if (cnt_q != 32'hFFFF_FFFF)
					cnt_q <= cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			loss_q <= loss_in;
			den_q  <= m;
			rem_q  <= 32'($signed({1'b0, m}) - flow_in);
			if (flow_ge_m)
				t_q <= '0;
			else if (flow_le_0)
				t_q <= T_W'(1) << FRAC_BITS;
			else
				t_q <= '0;
			if (stat.fast) begin
				exp_q <= (action == ACT_COMPUTE) ? lnd_val_q : 32'd0;
				pv_q  <= 1'b0;
			end
		end
		if (cmd.div_step) begin
			if (rs >= 33'(den_q)) begin
				rem_q <= 32'(rs - 33'(den_q));
				t_q   <= {t_q[T_W-2:0], 1'b1};
			end else begin
				rem_q <= rs[31:0];
				t_q   <= {t_q[T_W-2:0], 1'b0};
			end
		end
		if (cmd.mul_p)
			p_q <= P_W'(beta_q) * P_W'(t_q);
		if (cmd.mul_y) begin
			hi_q <= 57'(x30[55:30]) * 57'(LOG2E_Q30);
			lo_q <= xf_prod[60:30];
		end
		if (cmd.add_y)
			y_q <= 58'(hi_q) + 58'(lo_q);
		if (cmd.mul_g) begin
			g_q    <= g_prod[59:30];
			k_q    <= y_q[34:30];
			kbig_q <= |y_q[57:35];
			term_q <= Q30_ONE;
			esum_q <= 33'(Q30_ONE);
		end
		if (cmd.tay_mul)
			tp_q <= tg_prod[60:30];
		if (cmd.tay_div) begin
			term_q <= td_prod[64:34];
			if (cmd.tay_n[0])
				esum_q <= esum_q - $signed({2'b00, td_prod[64:34]});
			else
				esum_q <= esum_q + $signed({2'b00, td_prod[64:34]});
		end
		if (cmd.scale)
			sdr_q <= kbig_q ? 31'd0 : (e_pos >> k_q);
		if (cmd.mul_loss)
			prod_q <= 63'(mag) * 63'(sdr_q);
		if (cmd.commit) begin
			exp_q <= v[31:0];
			pv_q  <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sediment_delivery_export.sv =====
// Scan, clear and nodata items: the result is presented in the cycle after the transfer.
// Compute items: states DIV, XMUL, YMUL, YADD, GMUL, TMUL and TDIV per series term, SCALE,
// LMUL and COMMIT; DIV is skipped when travel time is clamped. The divider is bit-serial
// (FRAC_BITS steps); each term of the ten-term exponential series takes a multiply and a divide.
// One item at a time; the next transfer is taken once the result has left.
// arst_n clears the settings to defaults and the maximum, total and count to zero.
`default_nettype none
module sediment_delivery_export
	import sde_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,  // soil_loss, flow_count
	input  wire logic [1:0]   s_tuser,  // action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [159:0]      m_tdata,  // export_amount, flow_maximum, export_total, valid_pixels
	output logic              m_tuser   // pixel_valid
);

	sde_cmd_t  cmd;
	sde_stat_t stat;

	sde_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sde_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire
